// ===== src/vjb_pkg.sv =====
package vjb_pkg;

  localparam int unsigned BufferMs        = 2048;
  localparam int unsigned HistoryMs       = 100;
  localparam int unsigned MeasureBaseMs   = 100;
  localparam int unsigned MeasurePeriodMs = 5000;
  localparam int unsigned MaxRateKhz      = 8;

  typedef enum logic [1:0] {
    REQ_PKT   = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_DECODE   = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_RATE     = 2'd1,
    CFG_SPP      = 2'd2,
    CFG_INTERVAL = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] ModeSendOnly = 2'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] now_ms;
    logic [14:0]        decoded_count;
    logic signed [15:0] sample_value;
    logic signed [31:0] window_head_ms;
    logic signed [31:0] window_tail_ms;
    logic [11:0]        sample_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               underrun;
    logic signed [15:0] read_sample;
    logic               read_valid;
  } out_item_t;

endpackage

// ===== src/voice_jitter_buffer.sv =====
// voice jitter buffer
// in channel: in_valid_i / in_ready_o carry one request item (packet begin,
// sample write or sample read). out channel: out_valid_o / out_ready_i carry
// one result item for each packet-begin and read item; writes give none.
// cfg channel: cfg_valid_i / cfg_ready_o write one register by index, taken
// while the block is idle and no result is pending.
// throughput: sample writes and items without a result go back to back, one
// per cycle while the block is idle; a packet-begin or read item holds the
// input until its result has left the output register
// results: a read hit is registered through the store read and rd_pend_q,
// a miss is set straight from the read state; a packet result is set in
// S_WIN in send-only mode, in S_RUN on overflow or decode error, and in
// S_UNDER when accepted
// underrun with data still buffered: after the result, the store is cleared
// one sample per cycle, up to the store depth, with the input held off
// reset: control state and config registers reset; captured items and the
// sample store are not cleared, entries read before written are undefined
// stall: while the result waits with out_ready_i low, no further packet or
// read item is taken, but sample writes are still taken while the block is idle
module voice_jitter_buffer #(
  parameter int unsigned BUFFER_MS   = vjb_pkg::BufferMs,
  parameter int unsigned MAX_RATE_KHZ = vjb_pkg::MaxRateKhz
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vjb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vjb_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import vjb_pkg::*;

  localparam int unsigned Depth = MAX_RATE_KHZ * BUFFER_MS;
  localparam int unsigned AW    = $clog2(Depth + 1) - 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WIN   = 9'b000000010,
    S_HIST  = 9'b000000100,
    S_LAT   = 9'b000001000,
    S_FREE  = 9'b000010000,
    S_RUN   = 9'b000100000,
    S_UNDER = 9'b001000000,
    S_FILL  = 9'b010000000,
    S_READ  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  mode_q;
  logic [3:0]  rate_cfg_q;
  logic [12:0] spp_q;
  logic [9:0]  intv_q;

  logic [31:0] head_q, tail_q, timer_q, score_q, wpos_q;
  logic [14:0] left_q;

  logic [31:0] tick_q;
  logic [14:0] dec_q;
  logic [31:0] wh_q, wt_q;
  logic [11:0] idx_q;
  logic signed [47:0] free_q;
  logic [14:0] run_q;
  logic [31:0] fpos_q, fn_q;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        rd_pend_q;

  logic [15:0] mem [2**AW];
  logic [15:0] rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;
  logic [AW-1:0] mem_ra;
  logic        mem_re;

  logic [3:0] rate;
  assign rate = (rate_cfg_q == 4'd0) ? 4'd1 :
                (32'(rate_cfg_q) > MAX_RATE_KHZ) ? 4'(MAX_RATE_KHZ) : rate_cfg_q;

  logic is_idle;
  assign is_idle     = (state_q == S_IDLE);
  assign cfg_ready_o = is_idle && !out_valid_q && !rd_pend_q;
  assign in_ready_o  = is_idle && ((!out_valid_q && !rd_pend_q) ||
                       in_item_i.req_type == REQ_WRITE || in_item_i.req_type == REQ_NONE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // working values
  logic [31:0] span, tdiff, sc_new, new_tail;
  logic [31:0] wh_c, wt_c;
  logic [47:0] lim;
  always_comb begin
    tdiff    = tick_q - head_q;
    sc_new   = tail_q - tick_q - 32'(MeasureBaseMs);
    new_tail = tick_q + 32'(intv_q);
    wh_c = ($signed(wh_q - head_q) < 0) ? head_q : wh_q;
    wt_c = ($signed(wt_q - tail_q) > 0) ? tail_q : wt_q;
    span = wt_c - wh_c;
    lim  = 48'(span) * 48'(rate);
  end

  logic ovf, dec_err, late, fill_go, rd_hit;
  assign ovf     = free_q < $signed(48'(spp_q));
  assign dec_err = (dec_q == '0) || (free_q == '0);
  assign late    = $signed(tick_q - tail_q) > 0;
  assign fill_go = late && ($signed(tail_q - head_q) > 0);
  assign rd_hit  = (mode_q != ModeSendOnly) && ($signed(span) > 0) && (48'(idx_q) < lim);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wpos_q[AW-1:0];
    mem_wd = in_item_i.sample_value;
    mem_re = 1'b0;
    mem_ra = AW'(wh_c * 32'(rate) + 32'(idx_q));
    if (acc && in_item_i.req_type == REQ_WRITE && left_q != '0) begin
      mem_we = 1'b1;
    end else if (state_q == S_FILL && fn_q != '0) begin
      mem_we = 1'b1;
      mem_wa = fpos_q[AW-1:0];
      mem_wd = '0;
    end
    if (state_q == S_READ) mem_re = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc && in_item_i.req_type == REQ_PKT) state_d = S_WIN;
        else if (acc && in_item_i.req_type == REQ_READ) state_d = S_READ;
      end
      S_WIN:   state_d = (mode_q == ModeSendOnly) ? S_IDLE : S_HIST;
      S_HIST:  state_d = S_LAT;
      S_LAT:   state_d = S_FREE;
      S_FREE:  state_d = S_RUN;
      S_RUN:   state_d = (ovf || dec_err) ? S_IDLE : S_UNDER;
      S_UNDER: state_d = fill_go ? S_FILL : S_IDLE;
      S_FILL:  state_d = (fn_q <= 32'd1) ? S_IDLE : S_FILL;
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 2'd0;
      rate_cfg_q  <= 4'd8;
      spp_q       <= 13'd160;
      intv_q      <= 10'd20;
      head_q      <= '0;
      tail_q      <= '0;
      timer_q     <= '0;
      score_q     <= '0;
      wpos_q      <= '0;
      left_q      <= '0;
      free_q      <= '0;
      run_q       <= '0;
      fpos_q      <= '0;
      fn_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:     mode_q     <= cfg_data_i[1:0];
          CFG_RATE:     rate_cfg_q <= cfg_data_i[3:0];
          CFG_SPP:      spp_q      <= cfg_data_i[12:0];
          CFG_INTERVAL: intv_q     <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (mem_we && state_q != S_FILL) begin
        wpos_q <= wpos_q + 32'd1;
        left_q <= left_q - 15'd1;
      end
      rd_pend_q <= (state_q == S_READ) && rd_hit;
      if (rd_pend_q) begin
        out_valid_q      <= 1'b1;
        out_q.read_sample <= rdata_q;
      end
      unique case (state_q)
        S_WIN: begin
          if (mode_q == ModeSendOnly) begin
            out_valid_q <= 1'b1;
            out_q       <= '{status: ST_IGNORED, default: '0};
          end else if (tick_q + 32'(BUFFER_MS) - head_q > 32'(BUFFER_MS) * 32'd2) begin
            head_q <= tick_q - 32'(HistoryMs);
            tail_q <= tick_q - 32'(HistoryMs);
          end
        end
        S_HIST: begin
          if ($signed(tdiff) > $signed(32'(HistoryMs))) begin
            head_q <= tick_q - 32'(HistoryMs);
            if ($signed(tail_q - (tick_q - 32'(HistoryMs))) < 0)
              tail_q <= tick_q - 32'(HistoryMs);
          end
        end
        S_LAT: begin
          if ($signed(score_q) > $signed(sc_new) || $signed(score_q) <= 0) begin
            score_q <= sc_new;
            timer_q <= tick_q;
          end else if ($signed(tick_q - timer_q) >= $signed(32'(MeasurePeriodMs))) begin
            tail_q  <= tail_q - score_q;
            score_q <= '1;
          end
        end
        S_FREE: begin
          free_q <= (48'(signed'(32'(BUFFER_MS))) - 48'(signed'(tail_q - head_q)))
                    * 48'(rate);
        end
        S_RUN: begin
          if (ovf) begin
            out_valid_q <= 1'b1;
            out_q       <= '{status: ST_OVERFLOW, default: '0};
          end else begin
            if ($signed(48'(dec_q)) > free_q) run_q <= free_q[14:0];
            else run_q <= dec_q;
            if (dec_err) begin
              out_valid_q <= 1'b1;
              out_q       <= '{status: ST_DECODE, default: '0};
            end
          end
        end
        S_UNDER: begin
          out_valid_q    <= 1'b1;
          out_q          <= '{status: ST_ACCEPTED, underrun: late, default: '0};
          left_q         <= run_q;
          if (late) begin
            wpos_q <= new_tail * 32'(rate);
            tail_q <= new_tail + 32'(intv_q);
            if ($signed(tail_q - head_q) <= 0) begin
              head_q <= new_tail;
            end else begin
              fpos_q <= tail_q * 32'(rate);
              if ($signed(new_tail * 32'(rate) - tail_q * 32'(rate)) < 0) fn_q <= '0;
              else if (new_tail * 32'(rate) - tail_q * 32'(rate) > 32'(Depth))
                fn_q <= 32'(Depth);
              else fn_q <= new_tail * 32'(rate) - tail_q * 32'(rate);
            end
          end else begin
            wpos_q <= tail_q * 32'(rate);
            tail_q <= tail_q + 32'(intv_q);
          end
        end
        S_FILL: begin
          if (fn_q != '0) begin
            fn_q   <= fn_q - 32'd1;
            fpos_q <= fpos_q + 32'd1;
          end
        end
        S_READ: begin
          if (rd_hit) begin
            out_q <= '{status: ST_READ, read_valid: 1'b1, default: '0};
          end else begin
            out_valid_q <= 1'b1;
            out_q       <= '{status: ST_READ, default: '0};
          end
        end
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (acc) begin
      tick_q <= in_item_i.now_ms;
      dec_q  <= in_item_i.decoded_count;
      wh_q   <= in_item_i.window_head_ms;
      wt_q   <= in_item_i.window_tail_ms;
      idx_q  <= in_item_i.sample_index;
    end
  end

endmodule

// ===== src/vjb_checker.sv =====
module vjb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input vjb_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input vjb_pkg::out_item_t out_item_o,
  input logic               cfg_ready_o
);
  import vjb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped under stall");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_READ |-> !out_item_o.read_valid)
    else $error("read_valid on non-read result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.read_valid |-> out_item_o.read_sample == '0)
    else $error("sample nonzero when invalid");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o)
    else $error("cfg taken with result pending");

  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_item_i.req_type == REQ_PKT || in_item_i.req_type == REQ_READ) |-> !out_valid_o)
    else $error("item taken with result pending");

endmodule

bind voice_jitter_buffer vjb_checker u_vjb_checker (.*);
